// ===== rtl/accumulator_integer_calculator_core_macros.svh =====
// Assertion macros shared by the calculator RTL.
// Needs a clk and an active-high rst in the scope of each use.
`ifndef ACCUMULATOR_INTEGER_CALCULATOR_CORE_MACROS_SVH
`define ACCUMULATOR_INTEGER_CALCULATOR_CORE_MACROS_SVH

// Same-cycle implication.
`define AIC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define AIC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/aic_pkg.sv =====
// Shared types and constants for the accumulator calculator.
// No dependencies; imported by the datapath, controller, top level and testbench.
package aic_pkg;

  localparam int CMD_W  = 3;
  localparam int OPND_W = 32;
  localparam int ERR_W  = 2;

  localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SUB   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MUL   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DIV   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REM   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SQR   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_POW   = 3'd6;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd7;

  localparam logic [ERR_W-1:0] ERR_OK   = 2'd0;
  localparam logic [ERR_W-1:0] ERR_DIV0 = 2'd1;
  localparam logic [ERR_W-1:0] ERR_POW0 = 2'd2;

  // multiplier operand pairs
  localparam logic [1:0] MSEL_AB  = 2'd0;
  localparam logic [1:0] MSEL_AA  = 2'd1;
  localparam logic [1:0] MSEL_ACC = 2'd2;
  localparam logic [1:0] MSEL_SQ  = 2'd3;

  typedef struct packed {
    logic       load;
    logic       mul_start;
    logic [1:0] mul_sel;
    logic       div_start;
    logic       div_step;
    logic       pow_init;
    logic       pacc_load;
    logic       pbase_load;
    logic       finish;
  } ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             b_zero;
    logic             b_neg;
    logic             exp_zero;
    logic             exp_lsb;
    logic             mul_done;
    logic             div_done;
  } status_t;

endpackage

// ===== rtl/aic_mul.sv =====
// Iterative multiplier, 8 multiplier bits per cycle, result modulo 2^W.
// Depends on nothing; used by aic_datapath.
module aic_mul #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] x,
  input  logic [W-1:0] y,
  output logic         done,
  output logic [W-1:0] prod
);

  localparam int STEPS = (W + 7) / 8;
  localparam int CW    = $clog2(STEPS + 1);

  logic [W-1:0]  mcand;
  logic [W-1:0]  mplier;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W+7:0]  pp;

  assign pp = mcand * mplier[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= x;
      mplier <= y;
      prod   <= '0;
    end else if (busy) begin
      prod   <= prod + pp[W-1:0];
      mcand  <= mcand << 8;
      mplier <= mplier >> 8;
    end
  end

endmodule

// ===== rtl/aic_datapath.sv =====
// Datapath: accumulator, operand registers, radix-2 divider, power registers,
// result selection and output register. Uses aic_pkg and aic_mul.
module aic_datapath #(
  parameter int W = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  aic_pkg::ctrl_t                 ctrl,
  output aic_pkg::status_t               status,
  input  logic [aic_pkg::CMD_W-1:0]      in_cmd,
  input  logic signed [aic_pkg::OPND_W-1:0] in_left,
  input  logic signed [aic_pkg::OPND_W-1:0] in_right,
  output logic signed [aic_pkg::OPND_W-1:0] value,
  output logic [aic_pkg::ERR_W-1:0]      error_code
);
  import aic_pkg::*;

  localparam int DCW = $clog2(W + 1);

  logic [W-1:0]     acc;
  logic             chain;
  logic [CMD_W-1:0] cmd_r;
  logic [W-1:0]     a_r;
  logic [W-1:0]     b_r;

  logic signed [63:0] left64;
  logic signed [63:0] right64;
  assign left64  = 64'(in_left);
  assign right64 = 64'(in_right);

  // multiplier
  logic [W-1:0] mx;
  logic [W-1:0] my;
  logic [W-1:0] prod;
  logic         mul_done;
  logic [W-1:0] pacc;
  logic [W-1:0] pbase;
  logic [W-1:0] pexp;

  always_comb begin
    case (ctrl.mul_sel)
      MSEL_AB:  begin mx = a_r;   my = b_r;   end
      MSEL_AA:  begin mx = a_r;   my = a_r;   end
      MSEL_ACC: begin mx = pacc;  my = pbase; end
      default:  begin mx = pbase; my = pbase; end
    endcase
  end

  aic_mul #(.W(W)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (ctrl.mul_start),
    .x     (mx),
    .y     (my),
    .done  (mul_done),
    .prod  (prod)
  );

  // divider on magnitudes
  logic [W-1:0]   a_mag;
  logic [W-1:0]   b_mag;
  logic [W-1:0]   div_q;
  logic [W-1:0]   div_r;
  logic [W-1:0]   div_d;
  logic [DCW-1:0] div_cnt;
  logic [W:0]     trial;

  assign a_mag = a_r[W-1] ? (W'(0) - a_r) : a_r;
  assign b_mag = b_r[W-1] ? (W'(0) - b_r) : b_r;
  assign trial = {div_r, div_q[W-1]} - {1'b0, div_d};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (ctrl.div_start) begin
      div_cnt <= DCW'(W);
    end else if (ctrl.div_step) begin
      div_cnt <= div_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.div_start) begin
      div_q <= a_mag;
      div_r <= '0;
      div_d <= b_mag;
    end else if (ctrl.div_step) begin
      if (!trial[W]) begin
        div_r <= trial[W-1:0];
        div_q <= {div_q[W-2:0], 1'b1};
      end else begin
        div_r <= {div_r[W-2:0], div_q[W-1]};
        div_q <= {div_q[W-2:0], 1'b0};
      end
    end
  end

  // operands and power loop registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r <= in_cmd;
      a_r   <= chain ? acc : left64[W-1:0];
      b_r   <= right64[W-1:0];
    end
    if (ctrl.pow_init) begin
      pacc  <= W'(1);
      pbase <= a_r;
      pexp  <= b_r;
    end else begin
      if (ctrl.pacc_load) begin
        pacc <= prod;
      end
      if (ctrl.pbase_load) begin
        pbase <= prod;
        pexp  <= pexp >> 1;
      end
    end
  end

  // result selection
  logic [W-1:0]     res;
  logic [ERR_W-1:0] err;
  logic             b_zero;
  logic             a_zero;
  logic             a_one;
  logic             a_mone;
  logic             q_neg;

  assign b_zero = (b_r == '0);
  assign a_zero = (a_r == '0);
  assign a_one  = (a_r == W'(1));
  assign a_mone = (a_r == '1);
  assign q_neg  = a_r[W-1] ^ b_r[W-1];

  always_comb begin
    res = '0;
    err = ERR_OK;
    case (cmd_r)
      CMD_ADD: res = a_r + b_r;
      CMD_SUB: res = a_r - b_r;
      CMD_MUL, CMD_SQR: res = prod;
      CMD_DIV: begin
        if (b_zero) err = ERR_DIV0;
        else        res = q_neg ? (W'(0) - div_q) : div_q;
      end
      CMD_REM: begin
        if (b_zero) err = ERR_DIV0;
        else        res = a_r[W-1] ? (W'(0) - div_r) : div_r;
      end
      CMD_POW: begin
        if (!b_r[W-1])   res = pacc;
        else if (a_zero) err = ERR_POW0;
        else if (a_one)  res = W'(1);
        else if (a_mone) res = b_r[0] ? '1 : W'(1);
        else             res = '0;
      end
      default: res = '0;
    endcase
  end

  logic [W-1:0]        acc_next;
  logic signed [W-1:0] acc_next_s;
  logic signed [63:0]  acc64;

  assign acc_next   = (err == ERR_OK) ? res : acc;
  assign acc_next_s = acc_next;
  assign acc64      = 64'(acc_next_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      chain <= 1'b0;
    end else if (ctrl.finish && err == ERR_OK) begin
      acc   <= res;
      chain <= (cmd_r != CMD_CLEAR);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      value      <= acc64[OPND_W-1:0];
      error_code <= err;
    end
  end

  assign status.cmd      = cmd_r;
  assign status.b_zero   = b_zero;
  assign status.b_neg    = b_r[W-1];
  assign status.exp_zero = (pexp == '0);
  assign status.exp_lsb  = pexp[0];
  assign status.mul_done = mul_done;
  assign status.div_done = (div_cnt == '0);

endmodule

// ===== rtl/aic_ctrl.sv =====
// Controller state machine: sequences multiply, divide and power loops,
// and owns the handshakes. Uses aic_pkg and the assertion macros header.
`include "accumulator_integer_calculator_core_macros.svh"

module aic_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output aic_pkg::ctrl_t   ctrl,
  input  aic_pkg::status_t status
);
  import aic_pkg::*;

  localparam logic [3:0] ST_IDLE         = 4'd0;
  localparam logic [3:0] ST_EXEC         = 4'd1;
  localparam logic [3:0] ST_MUL_WAIT     = 4'd2;
  localparam logic [3:0] ST_DIV_RUN      = 4'd3;
  localparam logic [3:0] ST_POW_CHECK    = 4'd4;
  localparam logic [3:0] ST_POW_MUL_WAIT = 4'd5;
  localparam logic [3:0] ST_POW_SQ_START = 4'd6;
  localparam logic [3:0] ST_POW_SQ_WAIT  = 4'd7;
  localparam logic [3:0] ST_FIN          = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_valid_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    ctrl       = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ctrl.load  = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (status.cmd)
          CMD_MUL: begin
            ctrl.mul_start = 1'b1;
            ctrl.mul_sel   = MSEL_AB;
            state_next     = ST_MUL_WAIT;
          end
          CMD_SQR: begin
            ctrl.mul_start = 1'b1;
            ctrl.mul_sel   = MSEL_AA;
            state_next     = ST_MUL_WAIT;
          end
          CMD_DIV, CMD_REM: begin
            if (status.b_zero) begin
              state_next = ST_FIN;
            end else begin
              ctrl.div_start = 1'b1;
              state_next     = ST_DIV_RUN;
            end
          end
          CMD_POW: begin
            if (status.b_neg) begin
              state_next = ST_FIN;
            end else begin
              ctrl.pow_init = 1'b1;
              state_next    = ST_POW_CHECK;
            end
          end
          default: state_next = ST_FIN;
        endcase
      end
      ST_MUL_WAIT: begin
        if (status.mul_done) state_next = ST_FIN;
      end
      ST_DIV_RUN: begin
        if (status.div_done) state_next = ST_FIN;
        else                 ctrl.div_step = 1'b1;
      end
      ST_POW_CHECK: begin
        if (status.exp_zero) begin
          state_next = ST_FIN;
        end else if (status.exp_lsb) begin
          ctrl.mul_start = 1'b1;
          ctrl.mul_sel   = MSEL_ACC;
          state_next     = ST_POW_MUL_WAIT;
        end else begin
          state_next = ST_POW_SQ_START;
        end
      end
      ST_POW_MUL_WAIT: begin
        if (status.mul_done) begin
          ctrl.pacc_load = 1'b1;
          state_next     = ST_POW_SQ_START;
        end
      end
      ST_POW_SQ_START: begin
        ctrl.mul_start = 1'b1;
        ctrl.mul_sel   = MSEL_SQ;
        state_next     = ST_POW_SQ_WAIT;
      end
      ST_POW_SQ_WAIT: begin
        if (status.mul_done) begin
          ctrl.pbase_load = 1'b1;
          state_next      = ST_POW_CHECK;
        end
      end
      ST_FIN: begin
        // hold until the output register is free or being drained
        if (!out_valid || out_ready) begin
          ctrl.finish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (ctrl.finish)    out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else                out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `AIC_ASSERT_NOW(a_fin_no_overwrite, ctrl.finish, !out_valid || out_ready, "result overwritten")
  `AIC_ASSERT_NEXT(a_load_exec, ctrl.load, state == ST_EXEC, "accepted transaction not dispatched")
  `AIC_ASSERT_NOW(a_mul_done_wait, status.mul_done, state == ST_MUL_WAIT || state == ST_POW_MUL_WAIT || state == ST_POW_SQ_WAIT, "multiplier done outside a wait state")
  `AIC_ASSERT_NOW(a_div_no_overrun, ctrl.div_step, !status.div_done, "divider stepped past its last bit")

endmodule

// ===== rtl/accumulator_integer_calculator_core.sv =====
// Accumulator calculator top level, W = DATA_WIDTH. Add, sub, clear use neither
// multiplier nor divider; mul and square run the multiplier once; div and rem run
// the radix-2 divider, skipped on divide by zero; power with a non-negative
// exponent runs the shared 8-bit-per-cycle multiplier once or twice per exponent bit.
// One transaction in work at a time; next taken while a result waits.
// Synchronous reset clears the accumulator, the chain flag and all control.
module accumulator_integer_calculator_core #(
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [31:0] left_operand, [63:32] right_operand
  input  logic [2:0]  s_axis_tuser,  // [2:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [31:0] value
  output logic [1:0]  m_axis_tuser   // [1:0] error_code
);
  import aic_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  logic signed [OPND_W-1:0] left_operand;
  logic signed [OPND_W-1:0] right_operand;
  logic signed [OPND_W-1:0] value;
  logic [ERR_W-1:0]         error_code;

  assign left_operand  = s_axis_tdata[31:0];
  assign right_operand = s_axis_tdata[63:32];
  assign m_axis_tdata  = value;
  assign m_axis_tuser  = error_code;

  aic_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .ctrl      (ctrl),
    .status    (status)
  );

  aic_datapath #(.W(DATA_WIDTH)) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .status     (status),
    .in_cmd     (s_axis_tuser),
    .in_left    (left_operand),
    .in_right   (right_operand),
    .value      (value),
    .error_code (error_code)
  );

endmodule

// ===== verif/accumulator_integer_calculator_core_tb.sv =====
// Self-checking testbench for the accumulator calculator core.
// Uses aic_pkg and the core RTL. A clocked driver feeds commands, a clocked
// monitor predicts each result and compares it with what the core returns.
`timescale 1ns / 100ps

module accumulator_integer_calculator_core_tb;
  import aic_pkg::*;

  localparam int QUIET_TAIL = 150;  // last items run with no idling
  localparam int HOLD_AT    = 700;  // long receiver hold-off starts here
  localparam int HOLD_LEN   = 400;
  localparam int TAIL_WAIT  = 450;

  typedef struct {
    logic [CMD_W-1:0]  op;
    logic [OPND_W-1:0] lhs;
    logic [OPND_W-1:0] rhs;
    bit                drain;  // sender waits for all results before this one
  } calc_req_t;

  typedef struct {
    logic [OPND_W-1:0] value;
    logic [ERR_W-1:0]  err;
    logic [CMD_W-1:0]  op;
  } calc_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // [31:0] left_operand, [63:32] right_operand
  logic [2:0]  s_axis_tuser = '0;   // [2:0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [31:0] value
  logic [1:0]  m_axis_tuser;        // [1:0] error_code

  calc_req_t pending[$];
  calc_res_t expected[$];

  // calculator model state
  logic [OPND_W-1:0] acc_model = '0;
  bit                chained   = 1'b0;

  bit in_taken = 1'b0;
  int sent_count = 0;
  int results_seen = 0;
  int err_results = 0;
  int op_count[8];
  int errors = 0;

  accumulator_integer_calculator_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic logic [OPND_W-1:0] int_pow(input logic [OPND_W-1:0] base,
                                                input logic [OPND_W-1:0] ex);
    logic [OPND_W-1:0] prod, sq, e;
    prod = 1;
    sq   = base;
    e    = ex;
    while (e != 0) begin
      if (e[0]) prod = prod * sq;
      sq = sq * sq;
      e  = e >> 1;
    end
    return prod;
  endfunction

  // One command against the model: updates state, returns value and error code.
  function automatic void calc_step(input logic [CMD_W-1:0] op,
                                    input logic [OPND_W-1:0] lhs,
                                    input logic [OPND_W-1:0] rhs,
                                    output logic [OPND_W-1:0] val,
                                    output logic [ERR_W-1:0] ec);
    logic [OPND_W-1:0] a, res, mag_a, mag_b, q, m;
    logic [ERR_W-1:0]  e;
    a   = chained ? acc_model : lhs;
    res = '0;
    e   = ERR_OK;
    case (op)
      CMD_ADD: res = a + rhs;
      CMD_SUB: res = a - rhs;
      CMD_MUL: res = a * rhs;
      CMD_DIV, CMD_REM: begin
        if (rhs == 0) begin
          e = ERR_DIV0;
        end else begin
          mag_a = a[OPND_W-1] ? -a : a;
          mag_b = rhs[OPND_W-1] ? -rhs : rhs;
          q = mag_a / mag_b;
          m = mag_a % mag_b;
          if (op == CMD_DIV) res = (a[OPND_W-1] ^ rhs[OPND_W-1]) ? -q : q;
          else res = a[OPND_W-1] ? -m : m;
        end
      end
      CMD_SQR: res = a * a;
      CMD_POW: begin
        if (!rhs[OPND_W-1]) res = int_pow(a, rhs);
        else if (a == 0) e = ERR_POW0;
        else if (a == 1) res = 1;
        else if (a == '1) res = rhs[0] ? '1 : 1;
        else res = '0;  // truncated toward zero
      end
      default: res = '0;
    endcase
    if (e == ERR_OK) begin
      acc_model = res;
      chained   = (op != CMD_CLEAR);
    end
    val = acc_model;
    ec  = e;
  endfunction

  function automatic logic [OPND_W-1:0] pick_operand();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return 1;
      2:       return '1;
      3:       return 32'h8000_0000;
      4:       return 32'h7fff_ffff;
      5, 6, 7: return $urandom_range(0, 32) - 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OPND_W-1:0] pick_exponent();
    case ($urandom_range(0, 9))
      0, 1:    return -$urandom_range(1, 40);
      2:       return $urandom;
      default: return $urandom_range(0, 20);
    endcase
  endfunction

  task automatic add_item(input logic [CMD_W-1:0] op, input logic [OPND_W-1:0] lhs,
                          input logic [OPND_W-1:0] rhs, input bit drain = 1'b0);
    calc_req_t it;
    it.op    = op;
    it.lhs   = lhs;
    it.rhs   = rhs;
    it.drain = drain;
    pending.push_back(it);
  endtask

  // Sender: one transaction offered at a time, held until accepted.
  int src_gap = 0;
  int src_cyc = 0;
  bit src_idle = 1'b1;
  always @(negedge clk) begin
    logic nv;
    calc_req_t cur;
    nv = s_axis_tvalid;
    src_cyc++;
    if (src_cyc % 64 == 0) src_idle = ($urandom_range(0, 2) != 0);
    if (rst) begin
      nv = 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      nv = 1'b0;
      if (src_gap > 0) begin
        src_gap--;
      end else if (pending.size() > 0) begin
        if (pending[0].drain && expected.size() != 0) begin
          // paused until every outstanding result is back
        end else if (src_idle && pending.size() >= QUIET_TAIL &&
                     $urandom_range(0, 5) == 0) begin
          src_gap = $urandom_range(0, 12);
        end else begin
          cur = pending.pop_front();
          s_axis_tdata <= {cur.rhs, cur.lhs};
          s_axis_tuser <= cur.op;
          nv = 1'b1;
          sent_count++;
        end
      end
    end
    s_axis_tvalid <= nv;
  end

  // Receiver: random stalls plus one long hold-off to back the core up.
  int snk_gap = 0;
  int snk_cyc = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit snk_idle = 1'b1;
  always @(negedge clk) begin
    snk_cyc++;
    if (snk_cyc % 64 == 32) snk_idle = ($urandom_range(0, 2) != 0);
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (!hold_done && sent_count >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        m_axis_tready <= 1'b0;
      end else if (snk_idle && pending.size() >= QUIET_TAIL &&
                   $urandom_range(0, 4) == 0) begin
        snk_gap = $urandom_range(0, 12);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: check results first, then predict the newly accepted command.
  always @(posedge clk) begin
    calc_res_t want;
    calc_res_t fresh;
    logic [OPND_W-1:0] v;
    logic [ERR_W-1:0]  e;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected.size() == 0) begin
          report_mismatch("result with nothing outstanding", m_axis_tdata, '0);
        end else begin
          want = expected.pop_front();
          if (m_axis_tdata !== want.value)
            report_mismatch($sformatf("value (cmd %0d)", want.op), m_axis_tdata, want.value);
          if (m_axis_tuser !== want.err)
            report_mismatch($sformatf("error_code (cmd %0d)", want.op),
                            {30'd0, m_axis_tuser}, {30'd0, want.err});
          results_seen++;
          if (want.err != ERR_OK) err_results++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        calc_step(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32], v, e);
        fresh.value = v;
        fresh.err   = e;
        fresh.op    = s_axis_tuser;
        expected.push_back(fresh);
        op_count[s_axis_tuser]++;
      end
      in_taken <= s_axis_tvalid && s_axis_tready;
    end
  end

  initial begin
    logic [CMD_W-1:0] op;
    int roll;

    for (int i = 0; i < 8; i++) op_count[i] = 0;

    // directed: wrap, rounding, sign rules, error paths, power corner cases
    add_item(CMD_ADD, 32'h7fff_ffff, 32'd1);
    add_item(CMD_SUB, 32'h1234_5678, 32'd1);
    add_item(CMD_CLEAR, '1, '1);
    add_item(CMD_DIV, -32'sd7, 32'd2);
    add_item(CMD_CLEAR, '0, '0);
    add_item(CMD_REM, -32'sd7, 32'd2);
    add_item(CMD_CLEAR, '0, '0);
    add_item(CMD_DIV, 32'h8000_0000, '1);
    add_item(CMD_REM, 32'h0, '1);
    add_item(CMD_DIV, 32'h0, 32'd0);
    add_item(CMD_REM, 32'h0, 32'd0);
    add_item(CMD_CLEAR, '0, '0);
    add_item(CMD_DIV, 32'd5, 32'd0);         // error with no chain: left still used next
    add_item(CMD_MUL, 32'h7fff_ffff, 32'h8000_0000);
    add_item(CMD_SQR, '0, 32'hdead_beef);
    add_item(CMD_CLEAR, '0, '0);
    add_item(CMD_POW, 32'd0, 32'd0);
    add_item(CMD_CLEAR, '0, '0);
    add_item(CMD_POW, 32'd0, '1);            // zero to a negative power
    add_item(CMD_POW, 32'd1, -32'sd5);
    add_item(CMD_CLEAR, '0, '0);
    add_item(CMD_POW, '1, -32'sd3);
    add_item(CMD_POW, '0, -32'sd2);
    add_item(CMD_CLEAR, '0, '0);
    add_item(CMD_POW, 32'd2, -32'sd1);
    add_item(CMD_POW, 32'd3, 32'h7fff_ffff);

    // random commands with a mix of extreme, small and full-range operands
    for (int i = 0; i < 1424; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) op = CMD_CLEAR;
      else if (roll < 22) op = CMD_ADD;
      else if (roll < 34) op = CMD_SUB;
      else if (roll < 48) op = CMD_MUL;
      else if (roll < 62) op = CMD_DIV;
      else if (roll < 74) op = CMD_REM;
      else if (roll < 84) op = CMD_SQR;
      else op = CMD_POW;
      add_item(op, pick_operand(),
               (op == CMD_POW) ? pick_exponent() : pick_operand(),
               (i == 500) || (i == 1000));
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || s_axis_tvalid || expected.size() != 0)
      @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (expected.size() != 0)
      report_mismatch("results never returned", expected.size(), '0);

    $display("Covered %0d commands (add %0d sub %0d mul %0d div %0d rem %0d",
             sent_count, op_count[CMD_ADD], op_count[CMD_SUB], op_count[CMD_MUL],
             op_count[CMD_DIV], op_count[CMD_REM]);
    $display("  sqr %0d pow %0d clr %0d)",
             op_count[CMD_SQR], op_count[CMD_POW], op_count[CMD_CLEAR]);
    $display("Checked %0d results, %0d carrying an error code, with stalls on both sides",
             results_seen, err_results);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #100000000;
    $display("Timeout: run did not finish");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
